@@ design/oscmsd_pkg.sv @@
// ----------------------------------------------------------------------------
// OSC message stream decoder package
// Shared types, codes and constants for the decoder controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package oscmsd_pkg;

   localparam int MAX_TAGS_DEF  = 16;
   localparam int RESULT_SLOTS  = 17;
   localparam int HEADER_SKIP   = 15;

   localparam logic [7:0] CH_SLASH = 8'h2F;
   localparam logic [7:0] CH_HASH  = 8'h23;
   localparam logic [7:0] CH_COMMA = 8'h2C;
   localparam logic [7:0] CH_INT   = 8'h69;
   localparam logic [7:0] CH_FLT   = 8'h66;
   localparam logic [7:0] CH_STR   = 8'h73;
   localparam logic [7:0] CH_TRUE  = 8'h54;
   localparam logic [7:0] CH_FALSE = 8'h46;

   typedef enum logic [3:0] {
      PH_IDLE        = 4'd0,
      PH_DROP        = 4'd1,
      PH_HEADER      = 4'd2,
      PH_SIZE        = 4'd3,
      PH_ELEM_START  = 4'd4,
      PH_TRAIL       = 4'd5,
      PH_ADDR        = 4'd6,
      PH_ADDR_PAD    = 4'd7,
      PH_COMMA       = 4'd8,
      PH_TAGS        = 4'd9,
      PH_TAG_PAD     = 4'd10,
      PH_ARG_WORD    = 4'd11,
      PH_ARG_STR     = 4'd12,
      PH_ARG_STR_PAD = 4'd13,
      PH_ARG_BOOL    = 4'd14
   } phase_type;

   typedef enum logic [3:0] {
      K_ADDR     = 4'd0,
      K_ADDR_END = 4'd1,
      K_INT      = 4'd2,
      K_FLOAT    = 4'd3,
      K_TRUE     = 4'd4,
      K_FALSE    = 4'd5,
      K_STR      = 4'd6,
      K_STR_END  = 4'd7,
      K_MSG_END  = 4'd8,
      K_ERROR    = 4'd9
   } kind_type;

   typedef enum logic [2:0] {
      TG_INT   = 3'd0,
      TG_FLOAT = 3'd1,
      TG_STR   = 3'd2,
      TG_TRUE  = 3'd3,
      TG_FALSE = 3'd4
   } tag_type;

   typedef enum logic [2:0] {
      OP_NONE,
      OP_ENTRY,
      OP_LOOP,
      OP_CASE,
      OP_BUNDLE,
      OP_LAST,
      OP_CLOSE
   } op_type;

   typedef enum logic [3:0] {
      CT_WAIT,
      CT_ENTRY,
      CT_LOOP_PRE,
      CT_CASE,
      CT_LOOP_ARG,
      CT_BUNDLE,
      CT_LAST,
      CT_CLOSE
   } ctrl_state_type;

   typedef struct packed {
      op_type op;
      logic   pre;
      logic   load;
   } cmd_type;

   typedef struct packed {
      logic go_pre;
      logic go_case;
      logic go_bundle;
      logic case_loop;
      logic loop_stay;
      logic can_push;
   } status_type;

endpackage

`default_nettype wire

@@ design/oscmsd_ctrl.sv @@
// ----------------------------------------------------------------------------
// OSC decoder controller
// Sequences the micro-steps that process one received byte.
// ----------------------------------------------------------------------------
`default_nettype none

module oscmsd_ctrl (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_tvalid,
   output logic                         req_tready,
   input  wire oscmsd_pkg::status_type  status,
   output oscmsd_pkg::cmd_type          cmd
);
   import oscmsd_pkg::*;

   ctrl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CT_WAIT;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         CT_WAIT: begin
            if (req_tvalid) state_in = CT_ENTRY;
         end
         CT_ENTRY: begin
            if (status.can_push) begin
               if (status.go_pre) state_in = CT_LOOP_PRE;
               else if (status.go_case) state_in = CT_CASE;
               else if (status.go_bundle) state_in = CT_BUNDLE;
               else state_in = CT_LAST;
            end
         end
         CT_LOOP_PRE: begin
            if (status.can_push && !status.loop_stay) state_in = CT_CASE;
         end
         CT_CASE: begin
            if (status.can_push) state_in = status.case_loop ? CT_LOOP_ARG : CT_BUNDLE;
         end
         CT_LOOP_ARG: begin
            if (status.can_push && !status.loop_stay) state_in = CT_BUNDLE;
         end
         CT_BUNDLE: begin
            if (status.can_push) state_in = CT_LAST;
         end
         CT_LAST: begin
            if (status.can_push) state_in = CT_CLOSE;
         end
         CT_CLOSE: begin
            if (status.can_push) state_in = CT_WAIT;
         end
         default: state_in = CT_WAIT;
      endcase
   end

   always_comb begin
      req_tready = 1'b0;
      cmd.op     = OP_NONE;
      cmd.pre    = 1'b0;
      cmd.load   = 1'b0;
      case (state_ff)
         CT_WAIT: begin
            req_tready = 1'b1;
            cmd.load   = req_tvalid;
         end
         CT_ENTRY:    if (status.can_push) cmd.op = OP_ENTRY;
         CT_LOOP_PRE: begin
            cmd.pre = 1'b1;
            if (status.can_push) cmd.op = OP_LOOP;
         end
         CT_CASE:     if (status.can_push) cmd.op = OP_CASE;
         CT_LOOP_ARG: if (status.can_push) cmd.op = OP_LOOP;
         CT_BUNDLE:   if (status.can_push) cmd.op = OP_BUNDLE;
         CT_LAST:     if (status.can_push) cmd.op = OP_LAST;
         CT_CLOSE:    if (status.can_push) cmd.op = OP_CLOSE;
         default:     cmd.op = OP_NONE;
      endcase
   end

endmodule

`default_nettype wire

@@ design/oscmsd_dp.sv @@
// ----------------------------------------------------------------------------
// OSC decoder datapath
// Parse registers, tag store, result counting and the output register pair.
// ----------------------------------------------------------------------------
`default_nettype none

module oscmsd_dp #(
   parameter int MAX_TAGS = oscmsd_pkg::MAX_TAGS_DEF
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic [7:0]              req_tdata,
   input  wire logic                    req_tlast,
   input  wire oscmsd_pkg::cmd_type     cmd,
   output oscmsd_pkg::status_type       status,
   output logic                         rsp_tvalid,
   input  wire logic                    rsp_tready,
   output logic [39:0]                  rsp_tdata,
   output logic [3:0]                   rsp_tuser,
   output logic                         rsp_tlast
);
   import oscmsd_pkg::*;

   localparam int TW = $clog2(MAX_TAGS + 1);
   localparam int IW = (MAX_TAGS > 1) ? $clog2(MAX_TAGS) : 1;

   logic [7:0]    byte_ff;
   logic          last_ff;
   phase_type     phase_ff, phase_in;
   logic [1:0]    wbc_ff, wbc_in;
   logic [31:0]   acc_ff, acc_in;
   tag_type       tag_ff [MAX_TAGS];
   logic [TW-1:0] tc_ff, tc_in;
   logic [TW-1:0] tp_ff, tp_in;
   logic          bun_ff, bun_in;
   logic [3:0]    hdr_ff, hdr_in;
   logic [31:0]   ebl_ff, ebl_in;
   logic [4:0]    n_ff, n_in;

   logic          pend_valid_ff;
   kind_type      pend_kind_ff;
   logic [31:0]   pend_value_ff;
   logic [4:0]    pend_arg_ff;
   logic          out_valid_ff;
   kind_type      out_kind_ff;
   logic [31:0]   out_value_ff;
   logic [4:0]    out_arg_ff;
   logic          out_last_ff;

   logic          em_want;
   logic          emit_ok;
   kind_type      em_kind;
   logic [31:0]   em_value;
   logic [4:0]    em_arg;
   logic          tag_we;
   tag_type       tag_wdata;
   logic          aligned;
   tag_type       cur_code;
   logic          tp_lt;
   logic          cur_bool;
   logic [4:0]    limit;
   logic [31:0]   acc_shift;
   logic [31:0]   ebl_dec;
   logic          slash;
   logic          can_push;

   assign can_push = !out_valid_ff || rsp_tready;
   assign slash    = (byte_ff == CH_SLASH);
   assign aligned  = ((wbc_ff + 2'd1) == 2'd0);
   assign cur_code = tag_ff[tp_ff[IW-1:0]];
   assign tp_lt    = (tp_ff < tc_ff);
   assign cur_bool = (cur_code == TG_TRUE) || (cur_code == TG_FALSE);
   assign limit    = cmd.pre ? 5'(RESULT_SLOTS - 2) : 5'(RESULT_SLOTS - 1);
   assign acc_shift = {acc_ff[23:0], byte_ff};
   assign ebl_dec  = (ebl_ff != 32'd0) ? ebl_ff - 32'd1 : ebl_ff;

   always_comb begin
      status.can_push  = can_push;
      status.go_pre    = (phase_ff == PH_ARG_BOOL);
      status.go_case   = (((phase_ff == PH_IDLE) || (phase_ff == PH_ELEM_START)) && slash) ||
                         ((phase_ff >= PH_TRAIL) && (phase_ff != PH_ARG_BOOL));
      status.go_bundle = (phase_ff == PH_ELEM_START) && !slash;
      status.case_loop = 1'b0;
      status.loop_stay = 1'b0;

      phase_in  = phase_ff;
      wbc_in    = wbc_ff;
      acc_in    = acc_ff;
      tc_in     = tc_ff;
      tp_in     = tp_ff;
      bun_in    = bun_ff;
      hdr_in    = hdr_ff;
      ebl_in    = ebl_ff;
      em_want   = 1'b0;
      em_kind   = K_ADDR;
      em_value  = 32'd0;
      em_arg    = 5'd0;
      tag_we    = 1'b0;
      tag_wdata = TG_INT;

      case (cmd.op)
         OP_ENTRY: begin
            case (phase_ff)
               PH_IDLE: begin
                  if (slash) begin
                     bun_in   = 1'b0;
                     phase_in = PH_ADDR;
                     wbc_in   = 2'd0;
                     acc_in   = 32'd0;
                     tc_in    = '0;
                     tp_in    = '0;
                  end else if (byte_ff == CH_HASH) begin
                     bun_in   = 1'b1;
                     hdr_in   = 4'(HEADER_SKIP);
                     phase_in = PH_HEADER;
                  end else begin
                     phase_in = PH_DROP;
                  end
               end
               PH_HEADER: begin
                  if (hdr_ff != 4'd0) hdr_in = hdr_ff - 4'd1;
                  if (hdr_ff <= 4'd1) begin
                     phase_in = PH_SIZE;
                     wbc_in   = 2'd0;
                     acc_in   = 32'd0;
                  end
               end
               PH_SIZE: begin
                  wbc_in = wbc_ff + 2'd1;
                  acc_in = acc_shift;
                  if (aligned) begin
                     ebl_in = acc_shift;
                     acc_in = 32'd0;
                     if (acc_shift != 32'd0) phase_in = PH_ELEM_START;
                  end
               end
               PH_ELEM_START: begin
                  if (slash) begin
                     phase_in = PH_ADDR;
                     wbc_in   = 2'd0;
                     acc_in   = 32'd0;
                     tc_in    = '0;
                     tp_in    = '0;
                  end else begin
                     phase_in = PH_TRAIL;
                  end
               end
               default: ;
            endcase
         end
         OP_LOOP: begin
            if (tp_lt && cur_bool && (n_ff < limit)) begin
               em_want  = 1'b1;
               em_kind  = (cur_code == TG_TRUE) ? K_TRUE : K_FALSE;
               em_arg   = 5'(tp_ff);
               tp_in    = tp_ff + TW'(1);
               status.loop_stay = 1'b1;
            end else if (!tp_lt) begin
               em_want  = 1'b1;
               em_kind  = K_MSG_END;
               em_arg   = 5'(tc_ff);
               phase_in = PH_TRAIL;
            end else if (cur_bool) begin
               if (cmd.pre) begin
                  em_want  = 1'b1;
                  em_kind  = K_ERROR;
                  em_arg   = 5'(tp_ff);
                  phase_in = PH_TRAIL;
               end else begin
                  phase_in = PH_ARG_BOOL;
               end
            end else if ((cur_code == TG_INT) || (cur_code == TG_FLOAT)) begin
               acc_in   = 32'd0;
               phase_in = PH_ARG_WORD;
            end else begin
               phase_in = PH_ARG_STR;
            end
         end
         OP_CASE: begin
            wbc_in = wbc_ff + 2'd1;
            case (phase_ff)
               PH_ADDR: begin
                  em_want = 1'b1;
                  if (byte_ff != 8'd0) begin
                     em_kind  = K_ADDR;
                     em_value = {24'd0, byte_ff};
                  end else begin
                     em_kind  = K_ADDR_END;
                     phase_in = aligned ? PH_COMMA : PH_ADDR_PAD;
                  end
               end
               PH_ADDR_PAD: if (aligned) phase_in = PH_COMMA;
               PH_COMMA: begin
                  if (byte_ff == CH_COMMA) begin
                     phase_in = PH_TAGS;
                  end else begin
                     em_want  = 1'b1;
                     em_kind  = K_ERROR;
                     em_arg   = 5'(tp_ff);
                     phase_in = PH_TRAIL;
                  end
               end
               PH_TAGS: begin
                  if (byte_ff == 8'd0) begin
                     if (aligned) begin
                        tp_in = '0;
                        status.case_loop = 1'b1;
                     end else begin
                        phase_in = PH_TAG_PAD;
                     end
                  end else begin
                     tag_we = 1'b1;
                     case (byte_ff)
                        CH_INT:   tag_wdata = TG_INT;
                        CH_FLT:   tag_wdata = TG_FLOAT;
                        CH_STR:   tag_wdata = TG_STR;
                        CH_TRUE:  tag_wdata = TG_TRUE;
                        CH_FALSE: tag_wdata = TG_FALSE;
                        default:  tag_we = 1'b0;
                     endcase
                     if (tag_we) begin
                        if (tc_ff < TW'(MAX_TAGS)) begin
                           tc_in = tc_ff + TW'(1);
                        end else begin
                           tag_we   = 1'b0;
                           em_want  = 1'b1;
                           em_kind  = K_ERROR;
                           em_arg   = 5'(tp_ff);
                           phase_in = PH_TRAIL;
                        end
                     end
                  end
               end
               PH_TAG_PAD: begin
                  if (aligned) begin
                     tp_in = '0;
                     status.case_loop = 1'b1;
                  end
               end
               PH_ARG_WORD: begin
                  acc_in = acc_shift;
                  if (aligned) begin
                     em_want  = 1'b1;
                     em_kind  = (cur_code == TG_INT) ? K_INT : K_FLOAT;
                     em_value = acc_shift;
                     em_arg   = 5'(tp_ff);
                     tp_in    = tp_ff + TW'(1);
                     status.case_loop = 1'b1;
                  end
               end
               PH_ARG_STR: begin
                  em_want = 1'b1;
                  em_arg  = 5'(tp_ff);
                  if (byte_ff != 8'd0) begin
                     em_kind  = K_STR;
                     em_value = {24'd0, byte_ff};
                  end else begin
                     em_kind = K_STR_END;
                     tp_in   = tp_ff + TW'(1);
                     if (aligned) status.case_loop = 1'b1;
                     else phase_in = PH_ARG_STR_PAD;
                  end
               end
               PH_ARG_STR_PAD: if (aligned) status.case_loop = 1'b1;
               default: ;
            endcase
         end
         OP_BUNDLE: begin
            if (bun_ff) begin
               ebl_in = ebl_dec;
               if (ebl_dec == 32'd0) begin
                  if (phase_ff >= PH_ADDR) begin
                     em_want = 1'b1;
                     em_kind = K_ERROR;
                     em_arg  = 5'(tp_ff);
                  end
                  phase_in = PH_SIZE;
                  wbc_in   = 2'd0;
                  acc_in   = 32'd0;
               end
            end
         end
         OP_LAST: begin
            if (last_ff) begin
               if ((phase_ff >= PH_ADDR) || (phase_ff == PH_ELEM_START) ||
                   ((phase_ff == PH_SIZE) && (wbc_ff != 2'd0))) begin
                  em_want = 1'b1;
                  em_kind = K_ERROR;
                  em_arg  = 5'(tp_ff);
               end
               phase_in = PH_IDLE;
               bun_in   = 1'b0;
               wbc_in   = 2'd0;
               acc_in   = 32'd0;
               hdr_in   = 4'd0;
               ebl_in   = 32'd0;
            end
         end
         default: ;
      endcase

      emit_ok = em_want && (n_ff < 5'(RESULT_SLOTS));
      if (cmd.op == OP_ENTRY) n_in = 5'd0;
      else n_in = n_ff + 5'(emit_ok);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         wbc_ff   <= 2'd0;
         acc_ff   <= 32'd0;
         tc_ff    <= '0;
         tp_ff    <= '0;
         bun_ff   <= 1'b0;
         hdr_ff   <= 4'd0;
         ebl_ff   <= 32'd0;
         n_ff     <= 5'd0;
      end else begin
         phase_ff <= phase_in;
         wbc_ff   <= wbc_in;
         acc_ff   <= acc_in;
         tc_ff    <= tc_in;
         tp_ff    <= tp_in;
         bun_ff   <= bun_in;
         hdr_ff   <= hdr_in;
         ebl_ff   <= ebl_in;
         n_ff     <= n_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         byte_ff <= req_tdata;
         last_ff <= req_tlast;
      end
      if (tag_we) tag_ff[tc_ff[IW-1:0]] <= tag_wdata;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         if (emit_ok) begin
            pend_valid_ff <= 1'b1;
            if (pend_valid_ff) out_valid_ff <= 1'b1;
            else if (rsp_tready) out_valid_ff <= 1'b0;
         end else if ((cmd.op == OP_CLOSE) && pend_valid_ff) begin
            pend_valid_ff <= 1'b0;
            out_valid_ff  <= 1'b1;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (emit_ok) begin
         pend_kind_ff  <= em_kind;
         pend_value_ff <= em_value;
         pend_arg_ff   <= em_arg;
      end
      if ((emit_ok || (cmd.op == OP_CLOSE)) && pend_valid_ff) begin
         out_kind_ff  <= pend_kind_ff;
         out_value_ff <= pend_value_ff;
         out_arg_ff   <= pend_arg_ff;
         out_last_ff  <= (cmd.op == OP_CLOSE);
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {3'd0, out_arg_ff, out_value_ff};
   assign rsp_tuser  = out_kind_ff;
   assign rsp_tlast  = out_last_ff;

   a_slots: assert property (@(posedge clock) disable iff (reset)
      n_ff <= 5'(RESULT_SLOTS))
      else $error("result count beyond slot limit");

   a_tags: assert property (@(posedge clock) disable iff (reset)
      (tp_ff <= tc_ff) && (tc_ff <= TW'(MAX_TAGS)))
      else $error("tag pointer or count out of range");

   a_close: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == OP_CLOSE) |=> !pend_valid_ff)
      else $error("pending result left after close");

endmodule

`default_nettype wire

@@ design/osc_message_stream_decoder.sv @@
// ----------------------------------------------------------------------------
// OSC message stream decoder
// Parses OSC 1.0 messages and bundles from a byte stream into typed items.
// ----------------------------------------------------------------------------
// One datagram byte is taken per request; each byte then runs through a short
// sequence in the controller. A byte outside a message (a datagram start other
// than '/', a dropped datagram, the bundle header, a size word) runs through
// accept, entry, datagram-end check and close. A byte inside a message runs
// through accept, entry, the message step, bundle-size check, datagram-end
// check and close; a bundle element that does not start with '/' skips the
// message step. Each pass through the argument loop adds a loop step, which
// repeats for each boolean tag it emits. Every step after the accept waits while
// the result register is full. The last result caused by a byte carries tlast.
`default_nettype none

module osc_message_stream_decoder #(
   parameter int MAX_TAGS = oscmsd_pkg::MAX_TAGS_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] data_byte
   input  wire logic        req_tlast,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [39:0]      rsp_tdata,   // [31:0] item_value, [36:32] arg_number
   output logic [3:0]       rsp_tuser,   // [3:0] item_kind
   output logic             rsp_tlast
);
   import oscmsd_pkg::*;

   cmd_type    cmd;
   status_type status;

   oscmsd_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   oscmsd_dp #(
      .MAX_TAGS (MAX_TAGS)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .cmd        (cmd),
      .status     (status),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

`default_nettype wire

@@ tb/sv/osc_message_stream_decoder_checker.sv @@
// ----------------------------------------------------------------------------
// OSC message stream decoder checker
// Watches the request and result channels and predicts the result items of
// every accepted datagram byte. Each accepted result is compared, field by
// field, with the oldest predicted item.
// ----------------------------------------------------------------------------
`default_nettype none

module osc_message_stream_decoder_checker #(
   parameter int MAX_TAGS = oscmsd_pkg::MAX_TAGS_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   input  wire logic        req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] data_byte
   input  wire logic        req_tlast,
   input  wire logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   input  wire logic [39:0] rsp_tdata,   // [31:0] item_value, [36:32] arg_number
   input  wire logic [3:0]  rsp_tuser,   // [3:0] item_kind
   input  wire logic        rsp_tlast,
   output int               fail_count,
   output int               pending
);
   timeunit 1ns;
   timeprecision 1ps;
   import oscmsd_pkg::*;

   typedef struct {
      kind_type    kind;
      logic [31:0] value;
      logic [4:0]  arg;
      logic        last;
   } osc_item_type;

   osc_item_type item_q[$];
   osc_item_type byte_items[$];

   phase_type   phase;
   logic [1:0]  word_count;
   logic [31:0] word_acc;
   tag_type     tag_mem [MAX_TAGS];
   logic [6:0]  tag_total;
   logic [6:0]  tag_ptr;
   logic        bundle_mode;
   logic [4:0]  skip_count;
   logic [31:0] elem_left;

   function void emit(kind_type kind, logic [31:0] value, logic [6:0] arg);
      osc_item_type it;
      if (byte_items.size() < RESULT_SLOTS) begin
         it.kind = kind;
         it.value = value;
         it.arg = arg[4:0];
         it.last = 1'b0;
         byte_items.push_back(it);
      end
   endfunction

   function void clear_parser();
      phase = PH_IDLE;
      word_count = 2'd0;
      word_acc = 32'd0;
      tag_total = 7'd0;
      tag_ptr = 7'd0;
      bundle_mode = 1'b0;
      skip_count = 5'd0;
      elem_left = 32'd0;
   endfunction

   function void open_message();
      phase = PH_ADDR;
      word_count = 2'd0;
      word_acc = 32'd0;
      tag_total = 7'd0;
      tag_ptr = 7'd0;
   endfunction

   function void abort_message();
      emit(K_ERROR, 32'd0, tag_ptr);
      phase = PH_TRAIL;
   endfunction

   function void advance_arg(int limit);
      while (tag_ptr < tag_total && tag_ptr < MAX_TAGS &&
             (tag_mem[tag_ptr] == TG_TRUE || tag_mem[tag_ptr] == TG_FALSE) &&
             byte_items.size() < limit) begin
         emit(tag_mem[tag_ptr] == TG_TRUE ? K_TRUE : K_FALSE, 32'd0, tag_ptr);
         tag_ptr++;
      end
      if (tag_ptr >= tag_total || tag_ptr >= MAX_TAGS) begin
         emit(K_MSG_END, 32'd0, tag_total);
         phase = PH_TRAIL;
         return;
      end
      case (tag_mem[tag_ptr])
         TG_INT, TG_FLOAT: begin
            word_acc = 32'd0;
            phase = PH_ARG_WORD;
         end
         TG_STR: phase = PH_ARG_STR;
         default: phase = PH_ARG_BOOL;
      endcase
   endfunction

   function void message_step(logic [7:0] b);
      logic aligned;
      tag_type code;
      logic known;
      aligned = (word_count == 2'd3);
      if (phase == PH_ARG_BOOL) begin
         advance_arg(RESULT_SLOTS - 2);
         if (phase == PH_ARG_BOOL) abort_message();
      end
      case (phase)
         PH_ADDR: begin
            if (b != 8'd0) begin
               emit(K_ADDR, {24'd0, b}, 7'd0);
            end else begin
               emit(K_ADDR_END, 32'd0, 7'd0);
               phase = aligned ? PH_COMMA : PH_ADDR_PAD;
            end
         end
         PH_ADDR_PAD: if (aligned) phase = PH_COMMA;
         PH_COMMA: begin
            if (b == CH_COMMA) phase = PH_TAGS;
            else abort_message();
         end
         PH_TAGS: begin
            if (b == 8'd0) begin
               if (aligned) begin
                  tag_ptr = 7'd0;
                  advance_arg(RESULT_SLOTS - 1);
               end else begin
                  phase = PH_TAG_PAD;
               end
            end else begin
               known = 1'b1;
               code = TG_INT;
               case (b)
                  CH_INT:   code = TG_INT;
                  CH_FLT:   code = TG_FLOAT;
                  CH_STR:   code = TG_STR;
                  CH_TRUE:  code = TG_TRUE;
                  CH_FALSE: code = TG_FALSE;
                  default:  known = 1'b0;
               endcase
               if (known) begin
                  if (tag_total < MAX_TAGS) begin
                     tag_mem[tag_total] = code;
                     tag_total++;
                  end else begin
                     abort_message();
                  end
               end
            end
         end
         PH_TAG_PAD: begin
            if (aligned) begin
               tag_ptr = 7'd0;
               advance_arg(RESULT_SLOTS - 1);
            end
         end
         PH_ARG_WORD: begin
            word_acc = {word_acc[23:0], b};
            if (aligned) begin
               emit((tag_ptr < MAX_TAGS && tag_mem[tag_ptr] == TG_INT) ? K_INT : K_FLOAT,
                    word_acc, tag_ptr);
               tag_ptr++;
               advance_arg(RESULT_SLOTS - 1);
            end
         end
         PH_ARG_STR: begin
            if (b != 8'd0) begin
               emit(K_STR, {24'd0, b}, tag_ptr);
            end else begin
               emit(K_STR_END, 32'd0, tag_ptr);
               tag_ptr++;
               if (aligned) advance_arg(RESULT_SLOTS - 1);
               else phase = PH_ARG_STR_PAD;
            end
         end
         PH_ARG_STR_PAD: if (aligned) advance_arg(RESULT_SLOTS - 1);
         default: ;
      endcase
      word_count = word_count + 2'd1;
   endfunction

   function void decode_byte(logic [7:0] b, logic last);
      osc_item_type it;
      byte_items.delete();
      case (phase)
         PH_IDLE: begin
            if (b == CH_SLASH) begin
               bundle_mode = 1'b0;
               open_message();
               message_step(b);
            end else if (b == CH_HASH) begin
               bundle_mode = 1'b1;
               skip_count = 5'(HEADER_SKIP);
               phase = PH_HEADER;
            end else begin
               phase = PH_DROP;
            end
         end
         PH_DROP: ;
         PH_HEADER: begin
            if (skip_count > 5'd0) skip_count--;
            if (skip_count == 5'd0) begin
               phase = PH_SIZE;
               word_count = 2'd0;
               word_acc = 32'd0;
            end
         end
         PH_SIZE: begin
            word_acc = {word_acc[23:0], b};
            word_count = word_count + 2'd1;
            if (word_count == 2'd0) begin
               elem_left = word_acc;
               word_acc = 32'd0;
               if (elem_left != 32'd0) phase = PH_ELEM_START;
            end
         end
         default: begin
            if (phase == PH_ELEM_START) begin
               if (b == CH_SLASH) begin
                  open_message();
                  message_step(b);
               end else begin
                  phase = PH_TRAIL;
               end
            end else begin
               message_step(b);
            end
            if (bundle_mode) begin
               if (elem_left > 32'd0) elem_left--;
               if (elem_left == 32'd0) begin
                  if (phase >= PH_ADDR) emit(K_ERROR, 32'd0, tag_ptr);
                  phase = PH_SIZE;
                  word_count = 2'd0;
                  word_acc = 32'd0;
               end
            end
         end
      endcase
      if (last) begin
         if (phase >= PH_ADDR || phase == PH_ELEM_START ||
             (phase == PH_SIZE && word_count != 2'd0))
            emit(K_ERROR, 32'd0, tag_ptr);
         phase = PH_IDLE;
         bundle_mode = 1'b0;
         word_count = 2'd0;
         word_acc = 32'd0;
         skip_count = 5'd0;
         elem_left = 32'd0;
      end
      foreach (byte_items[i]) begin
         it = byte_items[i];
         it.last = (i == byte_items.size() - 1);
         item_q.push_back(it);
      end
   endfunction

   task report(string what);
      $display("%0t: mismatch: %s", $realtime, what);
      fail_count++;
   endtask

   initial begin
      fail_count = 0;
      pending = 0;
   end

   always @(posedge clock) begin
      osc_item_type want;
      if (reset) begin
         clear_parser();
         item_q.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (item_q.size() == 0) begin
               report($sformatf("unexpected item kind %0d value %h", rsp_tuser,
                                rsp_tdata[31:0]));
            end else begin
               want = item_q.pop_front();
               if (rsp_tuser !== want.kind)
                  report($sformatf("kind %0d, want %0d", rsp_tuser, want.kind));
               if (rsp_tdata[31:0] !== want.value)
                  report($sformatf("value %h, want %h", rsp_tdata[31:0], want.value));
               if (rsp_tdata[36:32] !== want.arg)
                  report($sformatf("arg %0d, want %0d", rsp_tdata[36:32], want.arg));
               if (rsp_tlast !== want.last)
                  report($sformatf("tlast %b, want %b", rsp_tlast, want.last));
            end
         end
         if (req_tvalid && req_tready) decode_byte(req_tdata, req_tlast);
      end
      pending = item_q.size();
   end

endmodule

`default_nettype wire

@@ tb/sv/osc_message_stream_decoder_test.sv @@
// ----------------------------------------------------------------------------
// OSC message stream decoder testbench
// Sends directed and random OSC datagrams (messages, bundles, truncated and
// malformed ones, noise) in bursts against a stalling receiver; the checker
// predicts and compares every result item.
// ----------------------------------------------------------------------------
`default_nettype none

module osc_message_stream_decoder_test;
   timeunit 1ns;
   timeprecision 1ps;
   import oscmsd_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int BYTE_TARGET = 100;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;
   logic        req_tlast;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [39:0] rsp_tdata;
   logic [3:0]  rsp_tuser;
   logic        rsp_tlast;
   int          fail_count;
   int          pending;
   int          cycles;
   int          burst_left;
   int          sent;
   logic [7:0]  dgram[$];

   osc_message_stream_decoder dut (.*);
   osc_message_stream_decoder_checker checker_i (.*);

   initial begin
      clock = 0;
      forever #2 clock = ~clock;
   end

   initial cycles = 0;
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("osc_message_stream_decoder_test: done, errors");
         $finish;
      end
   end

   // stall on a changing pattern, with one long hold-off
   initial begin
      int mode;
      int span;
      int tick;
      rsp_tready = 0;
      mode = 0;
      span = 0;
      tick = 0;
      forever begin
         @(negedge clock);
         tick++;
         if (span == 0) begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(5, 60);
         end
         span--;
         if (tick >= 150 && tick < 450) rsp_tready <= 0;
         else case (mode)
            0: rsp_tready <= 1;
            1: rsp_tready <= ($urandom_range(0, 1) == 0);
            2: rsp_tready <= ($urandom_range(0, 9) != 0);
            default: rsp_tready <= ($urandom_range(0, 4) == 0);
         endcase
      end
   end

   task send_byte(logic [7:0] b, logic last);
      int gap;
      logic hit;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_tvalid <= 0;
            repeat (gap) @(negedge clock);
         end
      end
      burst_left--;
      req_tvalid <= 1;
      req_tdata <= b;
      req_tlast <= last;
      do begin
         #1;
         hit = req_tready;
         @(negedge clock);
      end while (!hit);
      sent++;
   endtask

   task send_dgram();
      foreach (dgram[i]) send_byte(dgram[i], i == dgram.size() - 1);
      dgram.delete();
   endtask

   function void pad_word();
      dgram.push_back(8'h00);
      while (dgram.size() % 4 != 0) dgram.push_back(8'h00);
   endfunction

   function string random_tags();
      string t;
      string pool;
      int n;
      pool = "ifsTF";
      t = "";
      n = ($urandom_range(0, 11) == 0) ? $urandom_range(14, 18) : $urandom_range(0, 6);
      repeat (n) begin
         if ($urandom_range(0, 9) == 0) t = {t, "x"};
         else t = {t, string'(pool[$urandom_range(0, 4)])};
      end
      return t;
   endfunction

   function void add_message(string addr, string tags);
      dgram.push_back(CH_SLASH);
      for (int i = 0; i < addr.len(); i++) dgram.push_back(addr[i]);
      pad_word();
      dgram.push_back(CH_COMMA);
      for (int i = 0; i < tags.len(); i++) dgram.push_back(tags[i]);
      pad_word();
      for (int i = 0; i < tags.len(); i++) begin
         if (tags[i] == CH_INT || tags[i] == CH_FLT) begin
            repeat (4) dgram.push_back(8'($urandom_range(0, 255)));
         end else if (tags[i] == CH_STR) begin
            repeat ($urandom_range(0, 6)) dgram.push_back(8'($urandom_range(1, 255)));
            pad_word();
         end
      end
   endfunction

   function string random_addr();
      string a;
      a = "";
      repeat ($urandom_range(0, 7)) a = {a, string'(8'($urandom_range(97, 122)))};
      return a;
   endfunction

   function void add_header();
      dgram.push_back(CH_HASH);
      repeat (15) dgram.push_back(8'($urandom_range(0, 255)));
   endfunction

   function void add_element(int skew, bit as_message);
      int start;
      int size;
      start = dgram.size();
      repeat (4) dgram.push_back(8'h00);
      if (as_message) add_message(random_addr(), random_tags());
      else repeat (4 * $urandom_range(1, 3)) dgram.push_back(8'($urandom_range(0, 255)));
      size = dgram.size() - start - 4 + skew;
      if (size < 0) size = 0;
      for (int i = 0; i < 4; i++) dgram[start + i] = 8'(size >> (8 * (3 - i)));
   endfunction

   initial begin
      int cut;
      reset = 1;
      req_tvalid = 0;
      req_tdata = 0;
      req_tlast = 0;
      burst_left = 0;
      sent = 0;
      repeat (11) @(negedge clock);
      reset <= 0;
      @(negedge clock);

      add_message("a", "ifsTFx");
      send_dgram();
      add_message("nc", "f");
      dgram[4] = 8'h3F;
      send_dgram();
      dgram.push_back(CH_SLASH);
      send_dgram();
      add_header();
      dgram = dgram[0:6];
      send_dgram();
      add_header();
      repeat (4) dgram.push_back(8'h00);
      add_element(0, 0);
      dgram.push_back(8'h00);
      dgram.push_back(8'h00);
      send_dgram();

      while (sent < BYTE_TARGET) begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: begin
               add_message(random_addr(), random_tags());
               if ($urandom_range(0, 3) == 0)
                  repeat (4) dgram.push_back(8'($urandom_range(0, 255)));
            end
            6, 7: begin
               add_header();
               repeat ($urandom_range(1, 2))
                  add_element($urandom_range(0, 5) == 0 ? -4 : 0, $urandom_range(0, 5) != 0);
            end
            8: repeat ($urandom_range(1, 12)) dgram.push_back(8'($urandom_range(0, 255)));
            default: begin
               add_message(random_addr(), random_tags());
               cut = $urandom_range(1, dgram.size());
               dgram = dgram[0:cut - 1];
            end
         endcase
         send_dgram();
      end
      req_tvalid <= 0;

      while (pending != 0) @(negedge clock);
      repeat (200) @(negedge clock);
      if (fail_count == 0 && pending == 0) begin
         $display("osc_message_stream_decoder_test: done, clean");
      end else begin
         $display("osc_message_stream_decoder_test: done, errors");
      end
      $finish;
   end

endmodule

`default_nettype wire
